### src/page_cache_replacement_defines.svh
// Assertion macros used by the checker file.
`ifndef PAGE_CACHE_REPLACEMENT_DEFINES_SVH
`define PAGE_CACHE_REPLACEMENT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");
// Next-cycle implication checked on every clock edge outside reset.
`define PCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");
`endif

### src/pcr_pkg.sv
// Shared types and constants of the page cache replacement block.
`default_nettype none
package pcr_pkg;
	localparam int ENTRIES = 16;
	localparam int SLOT_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int ENT_W = 1 + 16 + 16 + 9 + 32 + 32;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_GET = 3'd1;
	localparam logic [2:0] OP_CONTAINS = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;
	localparam logic [2:0] OP_CLEAR_ZR = 3'd5;

	localparam logic [1:0] STRAT_LRU = 2'd0;
	localparam logic [1:0] STRAT_MRU = 2'd1;
	localparam logic [1:0] STRAT_NEAR = 2'd2;

	localparam logic [2:0] REG_STRATEGY = 3'd0;
	localparam logic [2:0] REG_MAX = 3'd1;
	localparam logic [2:0] REG_CPAGE = 3'd2;
	localparam logic [2:0] REG_CZOOM = 3'd3;
	localparam logic [2:0] REG_CROT = 3'd4;
	localparam logic [2:0] REG_VFIRST = 3'd5;
	localparam logic [2:0] REG_VLAST = 3'd6;

	typedef struct packed {
		logic        valid;
		logic [15:0] page;
		logic [15:0] zoom;
		logic [8:0]  rot;
		logic [31:0] handle;
		logic [31:0] stamp;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_VREAD,
		ST_WRITE,
		ST_DONE
	} state_t;

	function automatic logic [15:0] abs16(input logic [15:0] a, input logic [15:0] b);
		abs16 = (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == '1) ? v : v + 32'd1;
	endfunction
endpackage
`default_nettype wire

### src/page_cache_replacement.sv
// A request is accepted in idle, then passes the scan of the 16 slots, decide, write-back
// and done; an add that evicts also passes a victim read, and clear-all goes straight to done.
// Throughput: one word at a time; the next word is taken once the result is gone.
// The scan reads the 16 slots one by one through the single entry RAM read port.
// Reset marks all slots empty through the live mask and clears counters and config registers at once.
`default_nettype none
module page_cache_replacement (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  op,
	input  wire logic [15:0] page,
	input  wire logic [15:0] zoom,
	input  wire logic [8:0]  rotation,
	input  wire logic [31:0] image_handle,
	input  wire logic        image_present,
	input  wire logic        match_zoom,
	input  wire logic        match_rotation,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [31:0]      data_out,
	output logic [4:0]       entry_count,
	output logic             evicted,
	output logic [15:0]      evicted_page,
	output logic [15:0]      evicted_zoom,
	output logic [8:0]       evicted_rotation,
	output logic [31:0]      hit_total,
	output logic [31:0]      miss_total
);
	logic                       ram_we;
	logic [pcr_pkg::SLOT_W-1:0] ram_waddr, ram_raddr;
	pcr_pkg::entry_t            ram_wdata, ram_rdata;
	logic [pcr_pkg::ENT_W-1:0]  rd_raw;

	pcr_ram #(.WIDTH(pcr_pkg::ENT_W), .DEPTH(pcr_pkg::ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(rd_raw)
	);

	assign ram_rdata = pcr_pkg::entry_t'(rd_raw);

	pcr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .valid(in_valid), .ready(in_ready), .op(op),
		.page(page), .zoom(zoom), .rotation(rotation), .image_handle(image_handle),
		.image_present(image_present), .match_zoom(match_zoom),
		.match_rotation(match_rotation), .out_valid(out_valid), .out_ready(out_ready),
		.found(found), .data_out(data_out), .entry_count(entry_count),
		.evicted(evicted), .evicted_page(evicted_page), .evicted_zoom(evicted_zoom),
		.evicted_rotation(evicted_rotation), .hit_total(hit_total),
		.miss_total(miss_total), .ram_we(ram_we), .ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
	);
endmodule
`default_nettype wire

### src/pcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module pcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/pcr_score.sv
// Victim ranking value for one table entry under the selected strategy.
`default_nettype none
module pcr_score (
	input  wire logic              [1:0]  strategy,
	input  wire pcr_pkg::entry_t          ent,
	input  wire logic              [15:0] current_page,
	input  wire logic              [15:0] current_zoom,
	input  wire logic              [8:0]  current_rotation,
	input  wire logic              [15:0] visible_first,
	input  wire logic              [15:0] visible_last,
	output logic                          cand,
	output logic                   [47:0] rank
);
	logic [15:0] pd;
	logic [15:0] zd;
	logic [47:0] near;

	always_comb begin
		pd = pcr_pkg::abs16(ent.page, current_page);
		zd = pcr_pkg::abs16(ent.zoom, current_zoom);
		// 409600 = 100 << 12, 102400 = 25 << 12
		near = ({32'd0, pd} * 48'd409600)
			+ ({32'd0, zd} * 48'd50)
			+ ((ent.rot != current_rotation) ? 48'd102400 : 48'd0);
		cand = !(ent.page >= visible_first && ent.page <= visible_last
			&& zd <= 16'd4 && ent.rot == current_rotation);
		// larger rank wins; strict compare keeps the lowest slot on ties
		case (strategy)
			pcr_pkg::STRAT_MRU:  rank = {16'd0, ent.stamp};
			pcr_pkg::STRAT_NEAR: rank = near;
			default:             rank = {16'd0, ~ent.stamp};
		endcase
	end
endmodule
`default_nettype wire

### src/pcr_ctrl.sv
// Sequencer: scans the entry RAM, selects victims and writes back.
`default_nettype none
module pcr_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [2:0]                   cfg_index,
	input  wire logic [15:0]                  cfg_data,
	input  wire logic                         valid,
	output logic                              ready,
	input  wire logic [2:0]                   op,
	input  wire logic [15:0]                  page,
	input  wire logic [15:0]                  zoom,
	input  wire logic [8:0]                   rotation,
	input  wire logic [31:0]                  image_handle,
	input  wire logic                         image_present,
	input  wire logic                         match_zoom,
	input  wire logic                         match_rotation,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              found,
	output logic [31:0]                       data_out,
	output logic [4:0]                        entry_count,
	output logic                              evicted,
	output logic [15:0]                       evicted_page,
	output logic [15:0]                       evicted_zoom,
	output logic [8:0]                        evicted_rotation,
	output logic [31:0]                       hit_total,
	output logic [31:0]                       miss_total,
	output logic                              ram_we,
	output logic [pcr_pkg::SLOT_W-1:0]        ram_waddr,
	output pcr_pkg::entry_t                   ram_wdata,
	output logic [pcr_pkg::SLOT_W-1:0]        ram_raddr,
	input  pcr_pkg::entry_t                   ram_rdata
);
	localparam logic [pcr_pkg::SLOT_W-1:0] LAST = pcr_pkg::SLOT_W'(pcr_pkg::ENTRIES - 1);

	pcr_pkg::state_t state_q, state_d;

	logic [1:0]  strategy_q;
	logic [4:0]  max_q;
	logic [15:0] cpage_q, czoom_q, vfirst_q, vlast_q;
	logic [8:0]  crot_q;

	logic [2:0]  op_q;
	logic [15:0] page_q, zoom_q;
	logic [8:0]  rot_q;
	logic [31:0] handle_q;
	logic        present_q, mz_q, mr_q;

	logic [pcr_pkg::SLOT_W-1:0] ridx_q;   // address issued this cycle
	logic [pcr_pkg::SLOT_W-1:0] didx_q;   // slot of data arriving now
	logic        dval_q;                  // read data valid
	logic        hit_q, free_q, best_q, bestc_q;
	logic [pcr_pkg::SLOT_W-1:0] hidx_q, fidx_q, bidx_q;
	logic [47:0] brank_q;
	pcr_pkg::entry_t hent_q;
	logic [pcr_pkg::CNT_W-1:0] count_q;
	logic [31:0] stamp_q, hits_q, miss_q;
	logic        vic_q;

	// live mask of clear-all: clearing it hides every slot at once, without writing the RAM
	logic [pcr_pkg::ENTRIES-1:0] live_q;

	// result register
	logic        ov_q, f_q, ev_q;
	logic [31:0] d_q;
	logic [15:0] ep_q, ez_q;
	logic [8:0]  er_q;

	logic        cand;
	logic [47:0] rank;
	logic [4:0]  limit;
	logic        scan_done;
	logic        zr_match;
	logic        better;

	pcr_score u_score (
		.strategy(strategy_q), .ent(ram_rdata), .current_page(cpage_q),
		.current_zoom(czoom_q), .current_rotation(crot_q),
		.visible_first(vfirst_q), .visible_last(vlast_q),
		.cand(cand), .rank(rank)
	);

	always_comb begin
		limit = (max_q == 5'd0) ? 5'd1
			: ((max_q > 5'(pcr_pkg::ENTRIES)) ? 5'(pcr_pkg::ENTRIES) : max_q);
		scan_done = dval_q && didx_q == LAST;
		zr_match = (!mz_q || pcr_pkg::abs16(ram_rdata.zoom, zoom_q) <= 16'd4)
			&& (!mr_q || ram_rdata.rot == rot_q);
		// near-current: candidates outrank non-candidates once any exists
		if (strategy_q == pcr_pkg::STRAT_NEAR) begin
			better = !best_q || (cand && !bestc_q) || (cand == bestc_q && rank > brank_q);
		end else begin
			better = !best_q || rank > brank_q;
		end
	end

	always_comb begin
		state_d = state_q;
		ready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = ridx_q;
		ram_wdata = ram_rdata;
		ram_raddr = ridx_q;
		case (state_q)
			pcr_pkg::ST_IDLE: begin
				ready = !ov_q;
				ram_raddr = '0;
				if (valid && !ov_q) begin
					if (op == pcr_pkg::OP_CLEAR) begin
						state_d = pcr_pkg::ST_DONE;
					end else begin
						state_d = pcr_pkg::ST_SCAN;
					end
				end
			end
			pcr_pkg::ST_SCAN: begin
				// clear by zoom/rotation drops entries as they stream past
				if (dval_q && op_q == pcr_pkg::OP_CLEAR_ZR && ram_rdata.valid
					&& live_q[didx_q] && zr_match) begin
					ram_we = 1'b1;
					ram_waddr = didx_q;
					ram_wdata = ram_rdata;
					ram_wdata.valid = 1'b0;
				end
				if (scan_done) begin
					state_d = pcr_pkg::ST_DECIDE;
				end
			end
			pcr_pkg::ST_DECIDE: begin
				ram_raddr = bidx_q;
				state_d = pcr_pkg::ST_WRITE;
				if (op_q == pcr_pkg::OP_ADD && present_q && !hit_q
					&& {1'b0, count_q} >= {1'b0, limit} && best_q) begin
					state_d = pcr_pkg::ST_VREAD;
				end
			end
			pcr_pkg::ST_VREAD: begin
				// retire the victim; the new key may land in a lower free slot
				ram_we = 1'b1;
				ram_waddr = bidx_q;
				ram_wdata = ram_rdata;
				ram_wdata.valid = 1'b0;
				state_d = pcr_pkg::ST_WRITE;
			end
			pcr_pkg::ST_WRITE: begin
				ram_waddr = hidx_q;
				ram_wdata = hent_q;
				ram_wdata.stamp = pcr_pkg::sat_inc(stamp_q);
				case (op_q)
					pcr_pkg::OP_ADD: begin
						if (present_q) begin
							if (hit_q) begin
								ram_we = 1'b1;
								ram_wdata.handle = handle_q;
							end else if (vic_q || free_q) begin
								ram_we = 1'b1;
								ram_waddr = vic_q ? bidx_q : fidx_q;
								// the new key goes to the free slot instead if that lies below the evicted slot
								if (vic_q && free_q && fidx_q < bidx_q) begin
									ram_waddr = fidx_q;
								end
								ram_wdata.valid = 1'b1;
								ram_wdata.page = page_q;
								ram_wdata.zoom = zoom_q;
								ram_wdata.rot = rot_q;
								ram_wdata.handle = handle_q;
							end
						end
					end
					pcr_pkg::OP_GET: ram_we = hit_q;
					pcr_pkg::OP_REMOVE: begin
						ram_we = hit_q;
						ram_wdata.valid = 1'b0;
					end
					default: ram_we = 1'b0;
				endcase
				state_d = pcr_pkg::ST_DONE;
			end
			pcr_pkg::ST_DONE: begin
				state_d = pcr_pkg::ST_IDLE;
			end
			default: state_d = pcr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= pcr_pkg::STRAT_LRU;
			max_q <= 5'd16;
			cpage_q <= '0;
			czoom_q <= 16'd4096;
			crot_q <= '0;
			vfirst_q <= '0;
			vlast_q <= '0;
			count_q <= '0;
			stamp_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			ov_q <= 1'b0;
			dval_q <= 1'b0;
			ridx_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pcr_pkg::REG_STRATEGY: strategy_q <= cfg_data[1:0];
					pcr_pkg::REG_MAX:      max_q <= cfg_data[4:0];
					pcr_pkg::REG_CPAGE:    cpage_q <= cfg_data;
					pcr_pkg::REG_CZOOM:    czoom_q <= cfg_data;
					pcr_pkg::REG_CROT:     crot_q <= cfg_data[8:0];
					pcr_pkg::REG_VFIRST:   vfirst_q <= cfg_data;
					pcr_pkg::REG_VLAST:    vlast_q <= cfg_data;
					default: ;
				endcase
			end
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			dval_q <= 1'b0;
			case (state_q)
				pcr_pkg::ST_IDLE: begin
					if (valid && !ov_q) begin
						ridx_q <= pcr_pkg::SLOT_W'(1);
						dval_q <= op != pcr_pkg::OP_CLEAR;
					end
				end
				pcr_pkg::ST_SCAN: begin
					if (!scan_done) begin
						dval_q <= 1'b1;
						ridx_q <= ridx_q + 1'b1;
					end
					if (dval_q && op_q == pcr_pkg::OP_CLEAR_ZR && ram_rdata.valid
						&& live_q[didx_q] && zr_match) begin
						count_q <= count_q - 1'b1;
					end
				end
				pcr_pkg::ST_WRITE: begin
					case (op_q)
						pcr_pkg::OP_ADD: begin
							if (present_q && (hit_q || vic_q || free_q)) begin
								stamp_q <= pcr_pkg::sat_inc(stamp_q);
								if (!hit_q && !vic_q) begin
									count_q <= count_q + 1'b1;
								end
							end
						end
						pcr_pkg::OP_GET: begin
							if (hit_q) begin
								stamp_q <= pcr_pkg::sat_inc(stamp_q);
								hits_q <= pcr_pkg::sat_inc(hits_q);
							end else begin
								miss_q <= pcr_pkg::sat_inc(miss_q);
							end
						end
						pcr_pkg::OP_REMOVE: begin
							if (hit_q) begin
								count_q <= count_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
				pcr_pkg::ST_DONE: begin
					ov_q <= 1'b1;
					if (op_q == pcr_pkg::OP_CLEAR) begin
						count_q <= '0;
						stamp_q <= '0;
						hits_q <= '0;
						miss_q <= '0;
						vfirst_q <= 16'd1;
						vlast_q <= 16'd0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pcr_pkg::ST_IDLE && valid && !ov_q) begin
			op_q <= op;
			page_q <= page;
			zoom_q <= zoom;
			rot_q <= rotation;
			handle_q <= image_handle;
			present_q <= image_present;
			mz_q <= match_zoom;
			mr_q <= match_rotation;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			best_q <= 1'b0;
			bestc_q <= 1'b0;
			vic_q <= 1'b0;
			didx_q <= '0;
		end
		if (dval_q) begin
			didx_q <= didx_q + 1'b1;
		end
		if (state_q == pcr_pkg::ST_SCAN && dval_q) begin
			if (ram_rdata.valid && live_q[didx_q]) begin
				if (!hit_q && ram_rdata.page == page_q && ram_rdata.zoom == zoom_q
					&& ram_rdata.rot == rot_q) begin
					hit_q <= 1'b1;
					hidx_q <= didx_q;
					hent_q <= ram_rdata;
				end
				if (better) begin
					best_q <= 1'b1;
					bestc_q <= cand;
					bidx_q <= didx_q;
					brank_q <= rank;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
				fidx_q <= didx_q;
			end
		end
		if (state_q == pcr_pkg::ST_DECIDE) begin
			f_q <= 1'b0;
			d_q <= '0;
			ev_q <= 1'b0;
			ep_q <= '0;
			ez_q <= '0;
			er_q <= '0;
			if (state_d == pcr_pkg::ST_VREAD) begin
				vic_q <= 1'b1;
			end
			case (op_q)
				pcr_pkg::OP_ADD: f_q <= present_q && (hit_q || free_q || state_d == pcr_pkg::ST_VREAD);
				pcr_pkg::OP_GET: begin
					f_q <= hit_q;
					d_q <= hit_q ? hent_q.handle : 32'd0;
				end
				pcr_pkg::OP_CONTAINS: f_q <= hit_q;
				default: ;
			endcase
		end
		if (state_q == pcr_pkg::ST_VREAD) begin
			ev_q <= 1'b1;
			ep_q <= ram_rdata.page;
			ez_q <= ram_rdata.zoom;
			er_q <= ram_rdata.rot;
			hent_q <= ram_rdata;
		end
		if (state_q == pcr_pkg::ST_IDLE && valid && !ov_q && op == pcr_pkg::OP_CLEAR) begin
			f_q <= 1'b0;
			d_q <= '0;
			ev_q <= 1'b0;
			ep_q <= '0;
			ez_q <= '0;
			er_q <= '0;
		end
	end

	// per-slot live mask; cleared at once by reset or clear-all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (state_q == pcr_pkg::ST_DONE && op_q == pcr_pkg::OP_CLEAR) begin
			live_q <= '0;
		end else if (ram_we && ram_wdata.valid) begin
			live_q[ram_waddr] <= 1'b1;
		end
	end

	assign out_valid = ov_q;
	assign found = f_q;
	assign data_out = d_q;
	assign entry_count = 5'(count_q);
	assign evicted = ev_q;
	assign evicted_page = ep_q;
	assign evicted_zoom = ez_q;
	assign evicted_rotation = er_q;
	assign hit_total = hits_q;
	assign miss_total = miss_q;
endmodule
`default_nettype wire

### src/pcr_checker.sv
// Port-level checks of the page cache replacement block, bound to the top level.
`default_nettype none
`include "page_cache_replacement_defines.svh"
module pcr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        found,
	input wire logic        evicted,
	input wire logic [31:0] data_out,
	input wire logic [4:0]  entry_count
);
	`PCR_ASSERT_IMP(a_no_take_while_full, clk, arst_n, out_valid, !in_ready)
	`PCR_ASSERT_NXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(data_out))
	`PCR_ASSERT_IMP(a_count_range, clk, arst_n, out_valid, entry_count <= 5'd16)
	`PCR_ASSERT_IMP(a_evict_found, clk, arst_n, out_valid && evicted, found)
	`PCR_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind page_cache_replacement pcr_checker u_pcr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .found(found), .evicted(evicted),
	.data_out(data_out), .entry_count(entry_count)
);
`default_nettype wire
